FILE: rtl/sctlw_pkg.sv
// shared types and constants of the supercover tile line walker
`default_nettype none

package sctlw_pkg;

    // fixed field widths of the stream payloads
    localparam int TILE_BITS      = 16;
    localparam int S_TDATA_W      = 32;   // tile_x, tile_y
    localparam int M_TDATA_W      = 32;   // cell_x, cell_y

    // parameter defaults
    localparam int MAX_SPAN_DEF   = 16;
    localparam int COORD_BITS_DEF = 16;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEW,
        ST_OLD,
        ST_STEP,
        ST_EXTB,
        ST_MAIN
    } ctrl_state_t;

    // which cell goes into the output register
    typedef enum logic [2:0] {
        SEL_NEW,     // vertex just accepted
        SEL_OLD,     // previous vertex
        SEL_A,       // major axis advanced, minor axis held
        SEL_B,       // minor axis advanced, major axis held
        SEL_MAIN     // major axis advanced, minor axis too on a minor step
    } cell_sel_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        logic      last;
        cell_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic walk;
        logic ovf;
        logic zero_len;
        logic minor;
        logic lt;
        logic gt;
        logic cnt_one;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/supercover_tile_line_walker.sv
// top level of the supercover tile line walker
`default_nettype none

// Takes polyline vertices as tile coordinates (tile_x, tile_y, and a start flag
// in s_tuser) and streams out every tile the lines touch, one tile per
// transaction. For each vertex the block sends the vertex tile; when the
// vertex continues a line it then sends the previous vertex tile and every
// tile crossed by the segment, including a neighbor on the old row or column (or
// both at an exact corner) at each minor-axis step. m_tlast marks the final tile
// of a vertex. A segment whose longer axis exceeds MAX_SPAN sends only its two
// endpoint tiles, both with m_tuser (span overflow) set. Duplicates are not
// removed. One vertex is worked at a time: a new vertex is accepted only when
// idle, then the walk unit produces one tile per cycle into the output
// register whenever output back-pressure does not stall it. Coordinates
// are masked to COORD_BITS bits (at most 16).

module supercover_tile_line_walker #(
    parameter int MAX_SPAN   = sctlw_pkg::MAX_SPAN_DEF,
    parameter int COORD_BITS = sctlw_pkg::COORD_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // vertex input
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [sctlw_pkg::S_TDATA_W-1:0]     s_tdata,   // tile_x [15:0], tile_y [31:16]
    input  wire                                 s_tuser,   // starts_line
    // tile output
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [sctlw_pkg::M_TDATA_W-1:0]     m_tdata,   // cell_x [15:0], cell_y [31:16]
    output logic                                m_tlast,   // last tile of the vertex
    output logic                                m_tuser    // span_overflow
);
    import sctlw_pkg::*;

    // command and status between controller and datapath
    dp_cmd_t    cmd;
    dp_status_t stat;

    // sequencer: accepts a vertex, then steps through the cells to send
    sctlw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // vertex history, bresenham error terms and output register
    sctlw_dp #(
        .MAX_SPAN   (MAX_SPAN),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

FILE: rtl/sctlw_ctrl.sv
// controller state machine of the supercover tile line walker
`default_nettype none

module sctlw_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire sctlw_pkg::dp_status_t stat,
    output sctlw_pkg::dp_cmd_t      cmd
);
    import sctlw_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_NEW;
            end
            ST_NEW: begin
                if (stat.out_free) state_next = stat.walk ? ST_OLD : ST_IDLE;
            end
            ST_OLD: begin
                if (stat.out_free) begin
                    state_next = (stat.ovf || stat.zero_len) ? ST_IDLE : ST_STEP;
                end
            end
            ST_STEP: begin
                if (stat.out_free) begin
                    if (!stat.minor) begin
                        state_next = stat.cnt_one ? ST_IDLE : ST_STEP;
                    end else if (!stat.lt && !stat.gt) begin
                        state_next = ST_EXTB;
                    end else begin
                        state_next = ST_MAIN;
                    end
                end
            end
            ST_EXTB: begin
                if (stat.out_free) state_next = ST_MAIN;
            end
            ST_MAIN: begin
                if (stat.out_free) state_next = stat.cnt_one ? ST_IDLE : ST_STEP;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '{load: 1'b0, emit: 1'b0, last: 1'b0, sel: SEL_NEW};
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_NEW: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_NEW;
                cmd.last = !stat.walk;
            end
            ST_OLD: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_OLD;
                cmd.last = stat.ovf || stat.zero_len;
            end
            ST_STEP: begin
                cmd.emit = stat.out_free;
                if (!stat.minor) begin
                    cmd.sel  = SEL_MAIN;
                    cmd.last = stat.cnt_one;
                end else begin
                    cmd.sel  = stat.gt ? SEL_B : SEL_A;
                end
            end
            ST_EXTB: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_B;
            end
            ST_MAIN: begin
                cmd.emit = stat.out_free;
                cmd.sel  = SEL_MAIN;
                cmd.last = stat.cnt_one;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_load_to_new: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_NEW)
        else $error("accepted vertex did not start emission");

    a_extb_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXTB |-> $past(state_reg) == ST_STEP || $past(state_reg) == ST_EXTB)
        else $error("second corner cell without a preceding step");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.last) |=> state_reg == ST_IDLE)
        else $error("final cell of a vertex did not return to idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/sctlw_dp.sv
// datapath of the supercover tile line walker: vertex store, walk registers, output register
`default_nettype none

module sctlw_dp #(
    parameter int MAX_SPAN   = sctlw_pkg::MAX_SPAN_DEF,
    parameter int COORD_BITS = sctlw_pkg::COORD_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire  [sctlw_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire                                 s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [sctlw_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser,
    input  wire  sctlw_pkg::dp_cmd_t            cmd,
    output sctlw_pkg::dp_status_t               stat
);
    import sctlw_pkg::*;

    localparam int CW = (COORD_BITS < TILE_BITS) ? COORD_BITS : TILE_BITS;
    localparam int SW = $clog2(MAX_SPAN + 1);
    localparam int EW = SW + 3;

    // vertex history
    logic [CW-1:0] prev_x_reg, prev_y_reg;
    logic          have_prev_reg;

    // per-vertex walk state
    logic [CW-1:0] vx_reg, vy_reg;
    logic [CW-1:0] x_reg, y_reg;
    logic          xneg_reg, yneg_reg, xmaj_reg;
    logic [SW-1:0] dmaj_reg, dmin_reg, cnt_reg;
    logic [EW-1:0] err_reg, errp_reg;
    logic          walk_reg, ovf_reg, zero_reg;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [TILE_BITS-1:0] cell_x_reg, cell_y_reg;
    logic                 last_reg, ovf_out_reg;

    // segment setup from the incoming vertex
    logic [CW-1:0] in_x, in_y;
    logic [CW:0]   diff_x, diff_y;
    logic [CW-1:0] adx, ady, span, span_minor;
    logic          xmaj_w, span_big, walk_w;

    assign in_x   = s_tdata[CW-1:0];
    assign in_y   = s_tdata[TILE_BITS +: CW];
    assign diff_x = {1'b0, in_x} - {1'b0, prev_x_reg};
    assign diff_y = {1'b0, in_y} - {1'b0, prev_y_reg};
    assign adx    = diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
    assign ady    = diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
    assign xmaj_w = adx >= ady;
    assign span       = xmaj_w ? adx : ady;
    assign span_minor = xmaj_w ? ady : adx;
    assign span_big   = 32'(span) > 32'(MAX_SPAN);
    assign walk_w     = have_prev_reg && !s_tuser;

    // one walk step
    logic [EW-1:0] dmaj2, e1, e2, esum, err_next;
    logic          minor;
    logic [CW-1:0] xa, ya, x_next, y_next;
    logic          commit;

    assign dmaj2    = EW'({dmaj_reg, 1'b0});
    assign e1       = err_reg + EW'({dmin_reg, 1'b0});
    assign minor    = e1 > dmaj2;
    assign e2       = e1 - dmaj2;
    assign esum     = e2 + errp_reg;
    assign err_next = minor ? e2 : e1;

    assign xa     = xneg_reg ? x_reg - 1'b1 : x_reg + 1'b1;
    assign ya     = yneg_reg ? y_reg - 1'b1 : y_reg + 1'b1;
    assign x_next = (xmaj_reg || minor) ? xa : x_reg;
    assign y_next = (!xmaj_reg || minor) ? ya : y_reg;
    assign commit = cmd.emit && (cmd.sel == SEL_MAIN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end else if (cmd.load) begin
            have_prev_reg <= 1'b1;
            prev_x_reg    <= in_x;
            prev_y_reg    <= in_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            vx_reg   <= in_x;
            vy_reg   <= in_y;
            x_reg    <= prev_x_reg;
            y_reg    <= prev_y_reg;
            xneg_reg <= diff_x[CW];
            yneg_reg <= diff_y[CW];
            xmaj_reg <= xmaj_w;
            dmaj_reg <= span[SW-1:0];
            dmin_reg <= span_minor[SW-1:0];
            cnt_reg  <= span[SW-1:0];
            err_reg  <= EW'(span[SW-1:0]);
            errp_reg <= EW'(span[SW-1:0]);
            walk_reg <= walk_w;
            ovf_reg  <= walk_w && span_big;
            zero_reg <= span == '0;
        end else if (commit) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            err_reg  <= err_next;
            errp_reg <= err_next;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    // output cell selection
    logic [CW-1:0] sel_x, sel_y;
    logic          sel_ovf;

    always_comb begin
        sel_ovf = 1'b0;
        case (cmd.sel)
            SEL_NEW: begin
                sel_x   = vx_reg;
                sel_y   = vy_reg;
                sel_ovf = ovf_reg;
            end
            SEL_OLD: begin
                sel_x   = x_reg;
                sel_y   = y_reg;
                sel_ovf = ovf_reg;
            end
            SEL_A: begin
                sel_x = xmaj_reg ? xa : x_reg;
                sel_y = xmaj_reg ? y_reg : ya;
            end
            SEL_B: begin
                sel_x = xmaj_reg ? x_reg : xa;
                sel_y = xmaj_reg ? ya : y_reg;
            end
            default: begin
                sel_x = x_next;
                sel_y = y_next;
            end
        endcase
    end

    assign m_tvalid_next = cmd.emit || (m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            cell_x_reg  <= TILE_BITS'(sel_x);
            cell_y_reg  <= TILE_BITS'(sel_y);
            last_reg    <= cmd.last;
            ovf_out_reg <= sel_ovf;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {cell_y_reg, cell_x_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = ovf_out_reg;

    assign stat.walk     = walk_reg;
    assign stat.ovf      = ovf_reg;
    assign stat.zero_len = zero_reg;
    assign stat.minor    = minor;
    assign stat.lt       = esum < dmaj2;
    assign stat.gt       = esum > dmaj2;
    assign stat.cnt_one  = cnt_reg == SW'(1);
    assign stat.out_free = !m_tvalid_reg || m_tready;

`ifndef ASSERT_OFF
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> cnt_reg == SW'($past(cnt_reg) - 1'b1))
        else $error("walk step did not count down");
`endif

endmodule

`default_nettype wire

FILE: verif/line_walk_checker.sv
// checker for the supercover tile line walker: traces each segment and compares the tiles
`timescale 1ns / 1ps

module line_walk_checker (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    input  wire                             s_tready,
    input  wire [sctlw_pkg::S_TDATA_W-1:0]  s_tdata,   // tile_x [15:0], tile_y [31:16]
    input  wire                             s_tuser,   // starts_line
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire [sctlw_pkg::M_TDATA_W-1:0]  m_tdata,   // cell_x [15:0], cell_y [31:16]
    input  wire                             m_tlast,
    input  wire                             m_tuser,   // span_overflow
    output int                              fail_count,
    output int                              tiles_pending,
    output int                              vertex_count,
    output int                              tile_count,
    output int                              long_count,
    output int                              corner_count,
    output int                              steep_count
);

    localparam int SPAN_LIMIT = sctlw_pkg::MAX_SPAN_DEF;
    localparam int COORD_MASK = (1 << sctlw_pkg::COORD_BITS_DEF) - 1;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
        logic        ovf;
    } tile_t;

    tile_t expected_tiles[$];
    tile_t want;

    // previous vertex, as the block keeps it
    int   prev_x    = 0;
    int   prev_y    = 0;
    logic have_prev = 1'b0;

    int errors   = 0;
    int vertices = 0;
    int tiles    = 0;
    int longs    = 0;
    int corners  = 0;
    int steeps   = 0;

    function automatic void add_tile(int x, int y, logic ovf);
        tile_t t;
        t.x    = x[15:0];
        t.y    = y[15:0];
        t.last = 1'b0;
        t.ovf  = ovf;
        expected_tiles.insert(expected_tiles.size(), t);
    endfunction

    // every tile the new vertex causes, appended to the expected queue
    function automatic void trace_segment(logic [15:0] nx, logic [15:0] ny, logic new_line);
        int   x1, y1, x2, y2, dx, dy, xs, ys, x, y, err, errp, i;
        logic ovf;
        x2 = int'(nx) & COORD_MASK;
        y2 = int'(ny) & COORD_MASK;
        x1 = prev_x;
        y1 = prev_y;
        prev_x = x2;
        prev_y = y2;
        if (!have_prev || new_line) begin
            have_prev = 1'b1;
            add_tile(x2, y2, 1'b0);
        end else begin
            dx = x2 - x1;
            dy = y2 - y1;
            xs = (dx < 0) ? -1 : 1;
            ys = (dy < 0) ? -1 : 1;
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            ovf = (dx > SPAN_LIMIT) || (dy > SPAN_LIMIT);
            add_tile(x2, y2, ovf);
            add_tile(x1, y1, ovf);
            if (ovf) begin
                longs++;
            end else if (dx >= dy) begin
                // x-major walk, clipped neighbor at each row change
                x = x1;
                y = y1;
                err = dx;
                errp = dx;
                for (i = 0; i < dx; i++) begin
                    x += xs;
                    err += 2 * dy;
                    if (err > 2 * dx) begin
                        y += ys;
                        err -= 2 * dx;
                        if (err + errp < 2 * dx) begin
                            add_tile(x, y - ys, 1'b0);
                        end else if (err + errp > 2 * dx) begin
                            add_tile(x - xs, y, 1'b0);
                        end else begin
                            add_tile(x, y - ys, 1'b0);
                            add_tile(x - xs, y, 1'b0);
                            corners++;
                        end
                    end
                    add_tile(x, y, 1'b0);
                    errp = err;
                end
            end else begin
                // y-major walk, mirror image of the above
                steeps++;
                x = x1;
                y = y1;
                err = dy;
                errp = dy;
                for (i = 0; i < dy; i++) begin
                    y += ys;
                    err += 2 * dx;
                    if (err > 2 * dy) begin
                        x += xs;
                        err -= 2 * dy;
                        if (err + errp < 2 * dy) begin
                            add_tile(x - xs, y, 1'b0);
                        end else if (err + errp > 2 * dy) begin
                            add_tile(x, y - ys, 1'b0);
                        end else begin
                            add_tile(x - xs, y, 1'b0);
                            add_tile(x, y - ys, 1'b0);
                            corners++;
                        end
                    end
                    add_tile(x, y, 1'b0);
                    errp = err;
                end
            end
        end
        expected_tiles[expected_tiles.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string what, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, what, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                trace_segment(s_tdata[15:0], s_tdata[31:16], s_tuser);
                vertices++;
            end
            if (m_tvalid && m_tready) begin
                tiles++;
                if (expected_tiles.size() == 0) begin
                    $display("%0t ns: unexpected tile, expected none actual x=%0d y=%0d",
                             $time, m_tdata[15:0], m_tdata[31:16]);
                    errors++;
                end else begin
                    want = expected_tiles.pop_front();
                    check_field("cell_x", want.x, m_tdata[15:0]);
                    check_field("cell_y", want.y, m_tdata[31:16]);
                    check_field("last", {15'd0, want.last}, {15'd0, m_tlast});
                    check_field("span_overflow", {15'd0, want.ovf}, {15'd0, m_tuser});
                end
            end
        end
        tiles_pending <= expected_tiles.size();
        fail_count    <= errors;
        vertex_count  <= vertices;
        tile_count    <= tiles;
        long_count    <= longs;
        corner_count  <= corners;
        steep_count   <= steeps;
    end

endmodule

FILE: verif/testbench.sv
// testbench top: vertex stimulus, output back-pressure and verdict for the line walker
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 400;       // long receiver hold-off, fills the block
    localparam int MAX_GAP      = 18;
    localparam int SETTLE       = 3 * sctlw_pkg::MAX_SPAN_DEF + 20;
    localparam int CYCLE_LIMIT  = 2000000;   // far beyond the slowest clean run

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [sctlw_pkg::S_TDATA_W-1:0]  s_tdata  = '0;   // tile_x [15:0], tile_y [31:16]
    logic                             s_tuser  = 1'b0; // starts_line
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [sctlw_pkg::M_TDATA_W-1:0]  m_tdata;         // cell_x [15:0], cell_y [31:16]
    logic                             m_tlast;
    logic                             m_tuser;         // span_overflow

    int fail_count, tiles_pending, vertex_count, tile_count;
    int long_count, corner_count, steep_count;

    // one-shot request from the sender side for the long output hold-off
    logic stall_req   = 1'b0;
    int   cycle_count = 0;

    // sender pacing
    logic tx_gaps    = 1'b1;   // 0 gives a stretch of back-to-back vertices
    int   quiet_left = 0;      // vertices still to send with no gap
    int   sent       = 0;
    int   cur_x      = 0;
    int   cur_y      = 0;

    always #5 aclk = ~aclk;

    supercover_tile_line_walker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    line_walk_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .tiles_pending (tiles_pending),
        .vertex_count  (vertex_count),
        .tile_count    (tile_count),
        .long_count    (long_count),
        .corner_count  (corner_count),
        .steep_count   (steep_count)
    );

    // watchdog against a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tiles still pending",
                     cycle_count, tiles_pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // tile receiver: random stall before each transaction, in stretches with
    // and without stalls, plus one long hold-off when the sender asks for it
    initial begin : tile_sink
        int   gap;
        int   taken;
        logic rx_gaps;
        logic hold_done;
        taken     = 0;
        rx_gaps   = 1'b1;
        hold_done = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 40 == 0) rx_gaps = ($urandom_range(0, 2) != 0);
            if (stall_req && !hold_done) begin
                gap = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                gap = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    // one vertex transaction, preceded by the sender's own random gap
    task automatic send_vertex(input int x, input int y, input logic new_line);
        int gap;
        if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
        end else begin
            gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y[15:0], x[15:0]};
        s_tuser  <= new_line;
        do @(posedge aclk); while (!s_tready);
        cur_x = x;
        cur_y = y;
        sent++;
    endtask

    // hold the input until every predicted tile has come out
    task automatic drain_tiles;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tiles_pending != 0) @(posedge aclk);
    endtask

    // step a coordinate, folding back when it would leave the 16-bit tile range
    function automatic int step_coord(int base, int delta);
        int v;
        v = base + delta;
        if (v < 0 || v > 65535) v = base - delta;
        return v;
    endfunction

    function automatic int signed_draw(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    initial begin : vertex_source
        int   len, kind, k, d, next_drain;
        int   nx, ny;
        logic stall_issued;
        logic new_line;
        stall_issued = 1'b0;
        next_drain   = 100;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        send_vertex(0, 0, 1'b0);            // first vertex after reset, flag clear
        send_vertex(0, 0, 1'b0);            // zero-length segment
        send_vertex(16, 0, 1'b0);           // horizontal, exactly at the span limit
        send_vertex(16, 16, 1'b0);          // vertical, exactly at the span limit
        send_vertex(33, 16, 1'b0);          // one past the limit on x
        send_vertex(16, 33, 1'b0);          // one past the limit on both
        send_vertex(65535, 65535, 1'b1);    // all-ones corner, new line
        send_vertex(65520, 65519, 1'b0);    // steep, both steps negative
        send_vertex(65535, 65535, 1'b0);    // steep, both steps positive
        send_vertex(65530, 65530, 1'b0);    // exact diagonal, corner at every step
        send_vertex(0, 65535, 1'b0);        // huge jump, walk skipped
        send_vertex(100, 100, 1'b1);
        send_vertex(104, 103, 1'b0);        // shallow, bottom and left neighbors taken
        send_vertex(101, 105, 1'b0);        // shallow, mixed directions
        send_vertex(105, 101, 1'b0);
        send_vertex(100, 100, 1'b1);        // new line mid-stream on the same tile
        send_vertex(21845, 43690, 1'b1);    // alternating bit patterns
        send_vertex(43690, 21845, 1'b0);
        send_vertex(43690, 21845, 1'b1);
        send_vertex(43674, 21861, 1'b0);    // full diagonal: the most tiles per vertex
        drain_tiles();

        // random polylines
        while (sent < RANDOM_ITEMS + 20) begin
            if (sent >= next_drain) begin
                drain_tiles();
                next_drain += 100;
            end
            tx_gaps = ($urandom_range(0, 2) != 0);
            if (!stall_issued && sent >= 150) begin
                // keep offering vertices while the receiver holds off
                stall_req <= 1'b1;
                stall_issued = 1'b1;
                quiet_left = 20;
            end

            // start vertex: anywhere, or hugging the edges of the tile range
            if ($urandom_range(0, 3) == 0) begin
                nx = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(65515, 65535);
                ny = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(65515, 65535);
            end else begin
                nx = $urandom_range(0, 65535);
                ny = $urandom_range(0, 65535);
            end
            // now and then continue from the last line instead of starting a new one
            send_vertex(nx, ny, $urandom_range(0, 9) != 0);

            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++) begin
                kind = $urandom_range(0, 99);
                new_line = 1'b0;
                if (kind < 60) begin
                    nx = step_coord(cur_x, signed_draw(16));
                    ny = step_coord(cur_y, signed_draw(16));
                end else if (kind < 72) begin
                    d  = signed_draw(16);
                    nx = step_coord(cur_x, d);
                    ny = step_coord(cur_y, $urandom_range(0, 1) ? d : -d);
                end else if (kind < 78) begin
                    nx = cur_x;
                    ny = cur_y;
                end else if (kind < 84) begin
                    // one axis right at or just past the span limit
                    d = $urandom_range(16, 17);
                    if ($urandom_range(0, 1)) begin
                        nx = step_coord(cur_x, $urandom_range(0, 1) ? d : -d);
                        ny = step_coord(cur_y, signed_draw(16));
                    end else begin
                        nx = step_coord(cur_x, signed_draw(16));
                        ny = step_coord(cur_y, $urandom_range(0, 1) ? d : -d);
                    end
                end else if (kind < 92) begin
                    nx = $urandom_range(0, 65535);
                    ny = $urandom_range(0, 65535);
                end else begin
                    // broken line: restart flag in the middle
                    nx = step_coord(cur_x, signed_draw(16));
                    ny = step_coord(cur_y, signed_draw(16));
                    new_line = 1'b1;
                end
                send_vertex(nx, ny, new_line);
            end
        end

        drain_tiles();
        repeat (SETTLE) @(posedge aclk);

        $display("walked %0d vertices into %0d tiles: %0d long segments, %0d steep walks,",
                 vertex_count, tile_count, long_count, steep_count);
        $display("%0d exact corner crossings, one long output hold-off", corner_count);
        if (fail_count == 0 && tiles_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: supercover_tile_line_walker.f
rtl/sctlw_pkg.sv
rtl/sctlw_ctrl.sv
rtl/sctlw_dp.sv
rtl/supercover_tile_line_walker.sv
verif/line_walk_checker.sv
verif/testbench.sv
